// File: hw/rtl/sorp_pkg.sv
package sorp_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int NAX = 7;
  localparam int NTWIST = 6;
  localparam int GAIN_W = 48;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W = 66;
  localparam int SUM_W = 50;
  localparam int NUM_W = 33 + FRACTION_BITS;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int SQRT_STEPS = 32;

  typedef logic signed [31:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 3'd7;
  localparam logic [GAIN_W-1:0] GAINS_RESET = 48'h0100_1000_1000;
  localparam logic [15:0] STEP_RESET = 16'd6554;
  localparam word_t WORD_MAX = word_t'(32'h7FFF_FFFF);
  localparam word_t WORD_MIN = word_t'(32'h8000_0000);
  localparam word_t WORD_ONE = word_t'(64'd1 << FRACTION_BITS);

  typedef enum logic [1:0] {
    MODE_SETPOINT = 2'd0,
    MODE_POSE     = 2'd1,
    MODE_TWIST    = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RS_PROD,
    ST_RS_ROT,
    ST_RS_LIN,
    ST_RS_QUAT,
    ST_EULER,
    ST_NQ_SQ,
    ST_NQ_SQRT,
    ST_NQ_DSET,
    ST_NQ_DIV,
    ST_OUT_POSE,
    ST_OUT_RATE
  } state_t;

  typedef enum logic [3:0] {
    OPA_OMEGA,
    OPA_ZETA,
    OPA_W2,
    OPA_D2,
    OPA_STEP,
    OPA_ATT_W,
    OPA_ATT_X,
    OPA_ATT_Y,
    OPA_ATT_Z,
    OPA_ROT,
    OPA_POSE
  } opa_t;

  typedef enum logic [3:0] {
    OPB_OMEGA,
    OPB_ERR,
    OPB_RATE,
    OPB_ACC,
    OPB_ATT_X,
    OPB_ATT_Y,
    OPB_ATT_Z,
    OPB_TWIST,
    OPB_POSE
  } opb_t;

  // round half up at bit s, floor semantics on negatives
  function automatic prod_t rnd(prod_t v, int s);
    prod_t half;
    half = prod_t'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic word_t sat32(prod_t v);
    word_t r;
    if (v > prod_t'(WORD_MAX)) r = WORD_MAX;
    else if (v < prod_t'(WORD_MIN)) r = WORD_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/sorp_in_if.sv
interface sorp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] value_0;
  logic signed [31:0] value_1;
  logic signed [31:0] value_2;
  logic signed [31:0] value_3;
  logic signed [31:0] value_4;
  logic signed [31:0] value_5;
  logic signed [31:0] value_6;

  modport source (
    output valid, mode, value_0, value_1, value_2, value_3, value_4, value_5, value_6,
    input  ready
  );
  modport sink (
    input  valid, mode, value_0, value_1, value_2, value_3, value_4, value_5, value_6,
    output ready
  );
endinterface

// File: hw/rtl/sorp_out_if.sv
interface sorp_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic               last;
  logic signed [31:0] out_0;
  logic signed [31:0] out_1;
  logic signed [31:0] out_2;
  logic signed [31:0] out_3;
  logic signed [31:0] out_4;
  logic signed [31:0] out_5;
  logic signed [31:0] out_6;

  modport source (
    output valid, kind, last, out_0, out_1, out_2, out_3, out_4, out_5, out_6,
    input  ready
  );
  modport sink (
    input  valid, kind, last, out_0, out_1, out_2, out_3, out_4, out_5, out_6,
    output ready
  );
endinterface

// File: hw/rtl/second_order_reference_prefilter.sv
// Seven-axis second-order reference prefilter in signed Q16.16. Pose and twist
// beats only latch the measurement. A setpoint beat runs one Euler step on all
// seven axes through a single 33x33 multiplier, then renormalizes the
// quaternion: squares of its four components, a bit-serial square root and a
// bit-serial divide of each component. A setpoint that differs from the
// previous one first re-seeds the state from the measurement. If the
// quaternion norm is zero, the square root and divide are skipped. Then come
// the two result beats, pose then rate with last set.
// Input ready is held low from a setpoint until its rate beat is taken.
// Gains and step size are written through cfg_we / cfg_index / cfg_data.
module second_order_reference_prefilter (
  input  logic                               clk,
  input  logic                               rst_n,
  sorp_in_if.sink                            in_if,
  sorp_out_if.source                         out_if,
  input  logic                               cfg_we,
  input  logic [sorp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sorp_pkg::GAIN_W-1:0]        cfg_data
);
  import sorp_pkg::*;

  localparam logic [CNT_W-1:0] PROD_LAST = CNT_W'(8);
  localparam logic [2:0]       AX_LAST   = 3'd6;
  localparam logic [2:0]       AX_QW     = 3'd3;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             ph_r;
  logic [2:0]       grp_r;
  logic [1:0]       sub_r;
  logic [2:0]       ax_r;

  logic [GAIN_W-1:0] gains_r [NAX];
  logic [15:0]       step_r;
  word_t pose_r  [NAX];
  word_t rate_r  [NAX];
  word_t sref_r  [NAX];
  word_t mpose_r [NAX];
  word_t mtw_r   [NTWIST];

  sum_t  sp_r  [9];
  word_t rot_r [9];
  prod_t prod_r;
  logic [22:0] w2_r, d2_r;
  word_t err_r, acc_r;
  sum_t  tsum_r;
  logic [63:0] nsum_r;
  logic [31:0] root_r;
  logic [35:0] rem_r;
  logic [NUM_W-1:0] num_r, quot_r;
  logic [31:0] drem_r;

  word_t in_v [NAX];
  logic in_acc, differs;
  mode_t in_mode;

  opa_t opa;
  opb_t opb;
  logic [3:0] rot_idx;
  logic [2:0] tw_idx;
  logic mac_neg;
  logic signed [32:0] opa_v, opb_v;

  assign in_v[0] = in_if.value_0;
  assign in_v[1] = in_if.value_1;
  assign in_v[2] = in_if.value_2;
  assign in_v[3] = in_if.value_3;
  assign in_v[4] = in_if.value_4;
  assign in_v[5] = in_if.value_5;
  assign in_v[6] = in_if.value_6;
  assign in_mode = mode_t'(in_if.mode);
  assign in_acc  = in_if.valid && in_if.ready;

  always_comb begin
    differs = 1'b0;
    for (int i = 0; i < NAX; i++) begin
      if (sref_r[i] != in_v[i]) differs = 1'b1;
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (opa)
      OPA_OMEGA: opa_v = {17'b0, gains_r[ax_r][15:0]};
      OPA_ZETA:  opa_v = {17'b0, gains_r[ax_r][31:16]};
      OPA_W2:    opa_v = {10'b0, w2_r};
      OPA_D2:    opa_v = {10'b0, d2_r};
      OPA_STEP:  opa_v = {17'b0, step_r};
      OPA_ATT_W: opa_v = {mpose_r[3][31], mpose_r[3]};
      OPA_ATT_X: opa_v = {mpose_r[4][31], mpose_r[4]};
      OPA_ATT_Y: opa_v = {mpose_r[5][31], mpose_r[5]};
      OPA_ATT_Z: opa_v = {mpose_r[6][31], mpose_r[6]};
      OPA_ROT:   opa_v = {rot_r[rot_idx][31], rot_r[rot_idx]};
      OPA_POSE:  opa_v = {pose_r[ax_r][31], pose_r[ax_r]};
      default:   opa_v = '0;
    endcase
    unique case (opb)
      OPB_OMEGA: opb_v = {17'b0, gains_r[ax_r][15:0]};
      OPB_ERR:   opb_v = {err_r[31], err_r};
      OPB_RATE:  opb_v = {rate_r[ax_r][31], rate_r[ax_r]};
      OPB_ACC:   opb_v = {acc_r[31], acc_r};
      OPB_ATT_X: opb_v = {mpose_r[4][31], mpose_r[4]};
      OPB_ATT_Y: opb_v = {mpose_r[5][31], mpose_r[5]};
      OPB_ATT_Z: opb_v = {mpose_r[6][31], mpose_r[6]};
      OPB_TWIST: opb_v = {mtw_r[tw_idx][31], mtw_r[tw_idx]};
      OPB_POSE:  opb_v = {pose_r[ax_r][31], pose_r[ax_r]};
      default:   opb_v = '0;
    endcase
  end

  // ---------------- datapath combinational pieces ----------------
  prod_t term_mulf, mac_base, mac_sum;
  logic [64:0] sq_add;
  logic [63:0] nsum_nxt;
  logic [35:0] rem_sh, trial, rem_nxt;
  logic        sq_ge;
  logic [32:0] drem_sh, drem_nxt;
  logic        dge;
  logic [NUM_W-1:0] quot_nxt;
  logic [31:0] mag;
  prod_t div_ext;
  word_t div_res;
  prod_t rot_p, rot_q, rot_s, rot_v;
  logic  rot_sub, rot_diag;
  prod_t lim_v;
  word_t nr_sat, nr_clamp;

  assign term_mulf = rnd(prod_r, FRACTION_BITS);
  assign mac_base  = (sub_r == 2'd0) ? prod_t'(0) : prod_t'(tsum_r);
  assign mac_sum   = mac_neg ? (mac_base - term_mulf) : (mac_base + term_mulf);

  // saturating sum of squares
  assign sq_add   = {1'b0, nsum_r} + {1'b0, prod_r[63:0]};
  assign nsum_nxt = sq_add[64] ? '1 : sq_add[63:0];

  assign rem_sh  = {rem_r[33:0], nsum_r[63:62]};
  assign trial   = {2'b0, root_r, 2'b01};
  assign sq_ge   = rem_sh >= trial;
  assign rem_nxt = sq_ge ? (rem_sh - trial) : rem_sh;

  assign drem_sh  = {drem_r, num_r[NUM_W-1]};
  assign dge      = drem_sh >= {1'b0, root_r};
  assign drem_nxt = dge ? (drem_sh - {1'b0, root_r}) : drem_sh;
  assign quot_nxt = {quot_r[NUM_W-2:0], dge};
  assign div_ext  = prod_t'({{(PROD_W-NUM_W){1'b0}}, quot_nxt});
  assign div_res  = sat32(pose_r[ax_r][31] ? -div_ext : div_ext);
  assign mag      = pose_r[ax_r][31] ? 32'(-pose_r[ax_r]) : 32'(pose_r[ax_r]);

  // rotation entries from xx yy zz xy xz yz wx wy wz
  always_comb begin
    rot_p = prod_t'(sp_r[0]);
    rot_q = prod_t'(sp_r[0]);
    rot_sub = 1'b0;
    rot_diag = 1'b0;
    unique case (cnt_r[3:0])
      4'd0: begin rot_p = prod_t'(sp_r[1]); rot_q = prod_t'(sp_r[2]); rot_diag = 1'b1; end
      4'd1: begin rot_p = prod_t'(sp_r[3]); rot_q = prod_t'(sp_r[8]); rot_sub = 1'b1; end
      4'd2: begin rot_p = prod_t'(sp_r[4]); rot_q = prod_t'(sp_r[7]); end
      4'd3: begin rot_p = prod_t'(sp_r[3]); rot_q = prod_t'(sp_r[8]); end
      4'd4: begin rot_p = prod_t'(sp_r[0]); rot_q = prod_t'(sp_r[2]); rot_diag = 1'b1; end
      4'd5: begin rot_p = prod_t'(sp_r[5]); rot_q = prod_t'(sp_r[6]); rot_sub = 1'b1; end
      4'd6: begin rot_p = prod_t'(sp_r[4]); rot_q = prod_t'(sp_r[7]); rot_sub = 1'b1; end
      4'd7: begin rot_p = prod_t'(sp_r[5]); rot_q = prod_t'(sp_r[6]); end
      4'd8: begin rot_p = prod_t'(sp_r[0]); rot_q = prod_t'(sp_r[1]); rot_diag = 1'b1; end
      default: ;
    endcase
    rot_s = rot_sub ? (rot_p - rot_q) : (rot_p + rot_q);
    rot_v = rot_diag ? (prod_t'(WORD_ONE) - (rot_s <<< 1)) : (rot_s <<< 1);
  end

  // rate update and clamp to the axis limit
  always_comb begin
    lim_v = prod_t'({{(PROD_W-16){1'b0}}, gains_r[ax_r][47:32]}) <<< (FRACTION_BITS - 8);
    if (lim_v > prod_t'(WORD_MAX)) lim_v = prod_t'(WORD_MAX);
    nr_sat = sat32(prod_t'(rate_r[ax_r]) + rnd(prod_r, 16));
    if (prod_t'(nr_sat) > lim_v) nr_clamp = lim_v[31:0];
    else if (prod_t'(nr_sat) < -lim_v) nr_clamp = word_t'(-lim_v);
    else nr_clamp = nr_sat;
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_mode == MODE_SETPOINT) state_nxt = differs ? ST_RS_PROD : ST_EULER;
      end
      ST_RS_PROD: if (ph_r && cnt_r == PROD_LAST) state_nxt = ST_RS_ROT;
      ST_RS_ROT:  if (cnt_r == PROD_LAST) state_nxt = ST_RS_LIN;
      ST_RS_LIN:  if (ph_r && sub_r == 2'd2 && grp_r == 3'd2) state_nxt = ST_RS_QUAT;
      ST_RS_QUAT: if (ph_r && sub_r == 2'd2 && grp_r == 3'd3) state_nxt = ST_EULER;
      ST_EULER:   if (ph_r && grp_r == 3'd5 && ax_r == AX_LAST) state_nxt = ST_NQ_SQ;
      ST_NQ_SQ: begin
        if (ph_r && ax_r == AX_LAST) state_nxt = (nsum_nxt == '0) ? ST_OUT_POSE : ST_NQ_SQRT;
      end
      ST_NQ_SQRT: if (cnt_r == '0) state_nxt = ST_NQ_DSET;
      ST_NQ_DSET: state_nxt = ST_NQ_DIV;
      ST_NQ_DIV: begin
        if (cnt_r == '0) state_nxt = (ax_r == AX_LAST) ? ST_OUT_POSE : ST_NQ_DSET;
      end
      ST_OUT_POSE: if (out_if.ready) state_nxt = ST_OUT_RATE;
      ST_OUT_RATE: if (out_if.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    opa = OPA_POSE;
    opb = OPB_POSE;
    rot_idx = 4'd0;
    tw_idx = 3'd0;
    mac_neg = 1'b0;
    in_if.ready = (state_r == ST_IDLE);
    out_if.valid = (state_r == ST_OUT_POSE) || (state_r == ST_OUT_RATE);
    unique case (state_r)
      ST_RS_PROD: begin
        unique case (cnt_r[3:0])
          4'd0: begin opa = OPA_ATT_X; opb = OPB_ATT_X; end
          4'd1: begin opa = OPA_ATT_Y; opb = OPB_ATT_Y; end
          4'd2: begin opa = OPA_ATT_Z; opb = OPB_ATT_Z; end
          4'd3: begin opa = OPA_ATT_X; opb = OPB_ATT_Y; end
          4'd4: begin opa = OPA_ATT_X; opb = OPB_ATT_Z; end
          4'd5: begin opa = OPA_ATT_Y; opb = OPB_ATT_Z; end
          4'd6: begin opa = OPA_ATT_W; opb = OPB_ATT_X; end
          4'd7: begin opa = OPA_ATT_W; opb = OPB_ATT_Y; end
          4'd8: begin opa = OPA_ATT_W; opb = OPB_ATT_Z; end
          default: ;
        endcase
      end
      ST_RS_LIN: begin
        opa = OPA_ROT;
        opb = OPB_TWIST;
        rot_idx = 4'(grp_r) * 4'd3 + 4'(sub_r);
        tw_idx = 3'(sub_r);
      end
      ST_RS_QUAT: begin
        // half quaternion rate terms, one product per beat of the unit
        opb = OPB_TWIST;
        unique case ({grp_r[1:0], sub_r})
          4'b00_00: begin opa = OPA_ATT_X; tw_idx = 3'd3; mac_neg = 1'b1; end
          4'b00_01: begin opa = OPA_ATT_Y; tw_idx = 3'd4; mac_neg = 1'b1; end
          4'b00_10: begin opa = OPA_ATT_Z; tw_idx = 3'd5; mac_neg = 1'b1; end
          4'b01_00: begin opa = OPA_ATT_W; tw_idx = 3'd3; end
          4'b01_01: begin opa = OPA_ATT_Y; tw_idx = 3'd5; end
          4'b01_10: begin opa = OPA_ATT_Z; tw_idx = 3'd4; mac_neg = 1'b1; end
          4'b10_00: begin opa = OPA_ATT_W; tw_idx = 3'd4; end
          4'b10_01: begin opa = OPA_ATT_Z; tw_idx = 3'd3; end
          4'b10_10: begin opa = OPA_ATT_X; tw_idx = 3'd5; mac_neg = 1'b1; end
          4'b11_00: begin opa = OPA_ATT_W; tw_idx = 3'd5; end
          4'b11_01: begin opa = OPA_ATT_X; tw_idx = 3'd4; end
          4'b11_10: begin opa = OPA_ATT_Y; tw_idx = 3'd3; mac_neg = 1'b1; end
          default: ;
        endcase
      end
      ST_EULER: begin
        unique case (grp_r)
          3'd0: begin opa = OPA_OMEGA; opb = OPB_OMEGA; end
          3'd1: begin opa = OPA_ZETA;  opb = OPB_OMEGA; end
          3'd2: begin opa = OPA_W2;    opb = OPB_ERR; end
          3'd3: begin opa = OPA_D2;    opb = OPB_RATE; end
          3'd4: begin opa = OPA_STEP;  opb = OPB_RATE; end
          3'd5: begin opa = OPA_STEP;  opb = OPB_ACC; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    out_if.kind = (state_r == ST_OUT_RATE);
    out_if.last = (state_r == ST_OUT_RATE);
    out_if.out_0 = out_if.kind ? rate_r[0] : pose_r[0];
    out_if.out_1 = out_if.kind ? rate_r[1] : pose_r[1];
    out_if.out_2 = out_if.kind ? rate_r[2] : pose_r[2];
    out_if.out_3 = out_if.kind ? rate_r[3] : pose_r[3];
    out_if.out_4 = out_if.kind ? rate_r[4] : pose_r[4];
    out_if.out_5 = out_if.kind ? rate_r[5] : pose_r[5];
    out_if.out_6 = out_if.kind ? rate_r[6] : pose_r[6];
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      ph_r <= 1'b0;
      grp_r <= '0;
      sub_r <= '0;
      ax_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          ph_r <= 1'b0;
          grp_r <= '0;
          sub_r <= '0;
          ax_r <= '0;
        end
        ST_RS_PROD: begin
          ph_r <= !ph_r;
          if (ph_r) cnt_r <= (cnt_r == PROD_LAST) ? '0 : cnt_r + 1'b1;
        end
        ST_RS_ROT: cnt_r <= (cnt_r == PROD_LAST) ? '0 : cnt_r + 1'b1;
        ST_RS_LIN, ST_RS_QUAT: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            if (sub_r == 2'd2) begin
              sub_r <= '0;
              grp_r <= (state_r == ST_RS_LIN && grp_r == 3'd2) ? '0 :
                       (state_r == ST_RS_QUAT && grp_r == 3'd3) ? '0 : grp_r + 1'b1;
            end else begin
              sub_r <= sub_r + 1'b1;
            end
          end
        end
        ST_EULER: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            if (grp_r == 3'd5) begin
              grp_r <= '0;
              ax_r <= (ax_r == AX_LAST) ? AX_QW : ax_r + 1'b1;
            end else begin
              grp_r <= grp_r + 1'b1;
            end
          end
        end
        ST_NQ_SQ: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            ax_r <= (ax_r == AX_LAST) ? AX_QW : ax_r + 1'b1;
            if (ax_r == AX_LAST) cnt_r <= CNT_W'(SQRT_STEPS - 1);
          end
        end
        ST_NQ_SQRT: if (cnt_r != '0) cnt_r <= cnt_r - 1'b1;
        ST_NQ_DSET: cnt_r <= CNT_W'(NUM_W - 1);
        ST_NQ_DIV: begin
          if (cnt_r == '0) ax_r <= ax_r + 1'b1;
          else cnt_r <= cnt_r - 1'b1;
        end
        ST_OUT_POSE, ST_OUT_RATE: ;
        default: ;
      endcase
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NAX; i++) begin
        gains_r[i] <= GAINS_RESET;
        pose_r[i]  <= (i == 3) ? WORD_ONE : '0;
        mpose_r[i] <= (i == 3) ? WORD_ONE : '0;
        rate_r[i]  <= '0;
        sref_r[i]  <= '0;
      end
      for (int i = 0; i < NTWIST; i++) mtw_r[i] <= '0;
      step_r <= STEP_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_STEP) step_r <= cfg_data[15:0];
        else gains_r[cfg_index] <= cfg_data;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_mode)
              MODE_POSE: for (int i = 0; i < NAX; i++) mpose_r[i] <= in_v[i];
              MODE_TWIST: for (int i = 0; i < NTWIST; i++) mtw_r[i] <= in_v[i];
              MODE_SETPOINT: begin
                for (int i = 0; i < NAX; i++) begin
                  sref_r[i] <= in_v[i];
                  if (differs) pose_r[i] <= mpose_r[i];
                end
              end
              MODE_NONE: ;
              default: ;
            endcase
          end
        end
        ST_RS_LIN: if (ph_r && sub_r == 2'd2) rate_r[grp_r] <= sat32(mac_sum);
        ST_RS_QUAT: if (ph_r && sub_r == 2'd2) rate_r[AX_QW + grp_r] <= sat32(rnd(mac_sum, 1));
        ST_EULER: begin
          if (ph_r && grp_r == 3'd4) pose_r[ax_r] <= sat32(prod_t'(pose_r[ax_r]) + rnd(prod_r, 16));
          if (ph_r && grp_r == 3'd5) rate_r[ax_r] <= nr_clamp;
        end
        ST_NQ_DIV: if (cnt_r == '0) pose_r[ax_r] <= div_res;
        default: ;
      endcase
    end
  end

  // scratch and the shared units
  always_ff @(posedge clk) begin
    prod_r <= prod_t'(opa_v) * prod_t'(opb_v);
    unique case (state_r)
      ST_RS_PROD: if (ph_r) sp_r[cnt_r[3:0]] <= sum_t'(term_mulf);
      ST_RS_ROT: rot_r[cnt_r[3:0]] <= sat32(rot_v);
      ST_RS_LIN, ST_RS_QUAT: if (ph_r) tsum_r <= sum_t'(mac_sum);
      ST_EULER: begin
        if (ph_r) begin
          unique case (grp_r)
            3'd0: begin
              w2_r <= 23'(rnd(prod_r, 12));
              err_r <= sat32(prod_t'(sref_r[ax_r]) - prod_t'(pose_r[ax_r]));
            end
            3'd1: d2_r <= 23'(rnd(prod_r, 11));
            3'd2: tsum_r <= sum_t'(rnd(prod_r, 12));
            3'd3: acc_r <= sat32(prod_t'(tsum_r) - rnd(prod_r, 12));
            3'd5: if (ax_r == AX_LAST) nsum_r <= '0;
            default: ;
          endcase
        end
      end
      ST_NQ_SQ: begin
        if (ph_r) begin
          nsum_r <= nsum_nxt;
          root_r <= '0;
          rem_r <= '0;
        end
      end
      ST_NQ_SQRT: begin
        nsum_r <= nsum_r << 2;
        rem_r <= rem_nxt;
        root_r <= {root_r[30:0], sq_ge};
      end
      ST_NQ_DSET: begin
        // (|q| << F) + n/2 for a round-half-up quotient
        num_r <= {1'b0, mag, {FRACTION_BITS{1'b0}}} + NUM_W'(root_r >> 1);
        drem_r <= '0;
        quot_r <= '0;
      end
      ST_NQ_DIV: begin
        num_r <= num_r << 1;
        drem_r <= drem_nxt[31:0];
        quot_r <= quot_nxt;
      end
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_if.ready && out_if.valid))
    else $error("input ready while a result beat is pending");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.ready && out_if.last) |=> in_if.ready)
    else $error("not ready after the last result beat");

  a_measure_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.mode != MODE_SETPOINT) |=> in_if.ready)
    else $error("measurement beat did not complete in one cycle");

  a_setpoint_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.mode == MODE_SETPOINT) |=> !in_if.ready)
    else $error("setpoint beat did not start a run");

endmodule
